// File: sv/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types and constants for the per-source connection throttle: outcome
// codes, register indexes, register reset values and the per-source record.
// ----------------------------------------------------------------------------
package pst_pkg;

    localparam int TIME_W  = 48;
    localparam int IP_W    = 32;
    localparam int CNT_W   = 5;
    localparam int MS_W    = 16;
    localparam int MAXA_W  = 4;
    localparam int OUTC_W  = 3;
    localparam int RIDX_W  = 3;

    // outcome codes
    localparam logic [OUTC_W-1:0] OUTC_NEW       = 3'd0;
    localparam logic [OUTC_W-1:0] OUTC_BLOCKED   = 3'd1;
    localparam logic [OUTC_W-1:0] OUTC_COUNTED   = 3'd2;
    localparam logic [OUTC_W-1:0] OUTC_BLK_START = 3'd3;
    localparam logic [OUTC_W-1:0] OUTC_RESTART   = 3'd4;
    localparam logic [OUTC_W-1:0] OUTC_FULL      = 3'd5;

    // register indexes
    localparam logic [RIDX_W-1:0] REG_PENALTY = 3'd0;
    localparam logic [RIDX_W-1:0] REG_WINDOW  = 3'd1;
    localparam logic [RIDX_W-1:0] REG_MAXATT  = 3'd2;
    localparam logic [RIDX_W-1:0] REG_BURST   = 3'd3;
    localparam logic [RIDX_W-1:0] REG_BLOCK   = 3'd4;

    // register reset values
    localparam logic [MS_W-1:0]   PENALTY_RST = 16'd250;
    localparam logic [MS_W-1:0]   WINDOW_RST  = 16'd5000;
    localparam logic [MAXA_W-1:0] MAXATT_RST  = 4'd5;
    localparam logic [MS_W-1:0]   BURST_RST   = 16'd500;
    localparam logic [MS_W-1:0]   BLOCK_RST   = 16'd3000;

    localparam logic [CNT_W-1:0]  COUNT_MAX   = 5'd31;

    typedef struct packed {
        logic [MS_W-1:0]   penalty_ms;
        logic [MS_W-1:0]   window_ms;
        logic [MAXA_W-1:0] max_attempts;
        logic [MS_W-1:0]   burst_ms;
        logic [MS_W-1:0]   block_ms;
    } cfg_t;

    // per-source record held in the data memory
    typedef struct packed {
        logic [TIME_W-1:0] last_attempt;
        logic [TIME_W-1:0] block_until;
        logic [CNT_W-1:0]  attempt_count;
    } rec_t;

    // lookup result flags
    typedef struct packed {
        logic hit;
        logic full;
    } look_t;

endpackage

// File: sv/pst_cam.sv
// ----------------------------------------------------------------------------
// pst_cam
// Source address table: parallel compare of one address against all tracked
// sources, fill count, and allocation of the next free entry on a miss.
// ----------------------------------------------------------------------------
module pst_cam #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             lookup_en,
    input  logic [pst_pkg::IP_W-1:0]         ip,
    output pst_pkg::look_t                   look,
    output logic [$clog2(TABLE_ENTRIES)-1:0] idx
);

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);

    logic [pst_pkg::IP_W-1:0] ip_reg [TABLE_ENTRIES];
    logic [FILL_W-1:0]        fill_reg;
    logic [FILL_W-1:0]        fill_next;
    logic [TABLE_ENTRIES-1:0] match;
    logic [IDX_W-1:0]         hit_idx;
    logic                     alloc;

    // compare against every occupied entry; addresses are unique, so the
    // hit index is a plain OR of the matching positions
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            match[i] = (FILL_W'(i) < fill_reg) && (ip_reg[i] == ip);
            if (match[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    assign look.hit  = |match;
    assign look.full = (fill_reg == FILL_W'(TABLE_ENTRIES));
    assign idx       = look.hit ? hit_idx : fill_reg[IDX_W-1:0];
    assign alloc     = lookup_en && !look.hit && !look.full;
    assign fill_next = alloc ? fill_reg + FILL_W'(1) : fill_reg;

    // fill count: occupied entries always form a prefix of the table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // address store, written at the first free entry
    always_ff @(posedge clk)
    begin
        if (alloc)
        begin
            ip_reg[fill_reg[IDX_W-1:0]] <= ip;
        end
    end

    // a source is never tracked twice
    a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match))
        else $error("pst_cam: address matched more than one entry");

    // the table never grows past its size
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(TABLE_ENTRIES))
        else $error("pst_cam: fill count beyond table size");

    // an allocation grows the table by exactly one entry
    a_alloc_grow: assert property (@(posedge clk) disable iff (!rst_n)
        alloc |=> fill_reg == $past(fill_reg) + FILL_W'(1))
        else $error("pst_cam: allocation did not advance the fill count");

endmodule

// File: sv/per_source_connection_throttle_core.sv
// ----------------------------------------------------------------------------
// per_source_connection_throttle_core
// Per-source connection rate limiter. Each request carries a source address
// and the current millisecond time; the block answers accept or refuse with
// an outcome code, tracking sources in a table of TABLE_ENTRIES entries.
//
// Input channel: in_valid/in_ready with client_ip and now_ms.
// Output channel: out_valid/out_ready with accepted and outcome.
// Configuration: cfg_we, cfg_index, cfg_data; a write takes effect at the
// clock edge where cfg_we is high. Write only while no request is in flight.
// Pipeline: an accepted request is registered in the address lookup stage,
// then in the record update stage, then in the output register.
// Throughput: one request per cycle while out_ready holds; the lookup/update
// loop through the data memory is closed by forwarding the last written record.
// Reset: registers return to their defaults and the source table is empty;
// no clearing pass is needed, requests are taken right after reset.
// Receiver stall: the output register holds its result and the pipeline
// fills up; in_ready drops once both stages and the output are occupied.
// ----------------------------------------------------------------------------
module per_source_connection_throttle_core #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pst_pkg::IP_W-1:0]      client_ip,
    input  logic [pst_pkg::TIME_W-1:0]    now_ms,
    input  logic                          cfg_we,
    input  logic [pst_pkg::RIDX_W-1:0]    cfg_index,
    input  logic [pst_pkg::MS_W-1:0]      cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          accepted,
    output logic [pst_pkg::OUTC_W-1:0]    outcome
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int TW    = pst_pkg::TIME_W;

    pst_pkg::cfg_t                cfg_reg;

    // lookup stage
    logic                         s1_valid_reg;
    logic [pst_pkg::IP_W-1:0]     s1_ip_reg;
    logic [TW-1:0]                s1_now_reg;

    // update stage
    logic                         s2_valid_reg;
    logic [TW-1:0]                s2_now_reg;
    logic [IDX_W-1:0]             s2_idx_reg;
    pst_pkg::look_t               s2_look_reg;
    pst_pkg::rec_t                rd_rec_reg;

    // last write to the data memory
    logic                         fwd_valid_reg;
    logic [IDX_W-1:0]             fwd_idx_reg;
    pst_pkg::rec_t                fwd_rec_reg;

    // output register
    logic                         out_valid_reg;
    logic                         accepted_reg;
    logic [pst_pkg::OUTC_W-1:0]   outcome_reg;

    pst_pkg::rec_t                rec_mem [TABLE_ENTRIES];

    logic                         s1_adv;
    logic                         s2_adv;
    logic                         s2_ready;
    pst_pkg::look_t               cam_look;
    logic [IDX_W-1:0]             cam_idx;

    pst_pkg::rec_t                cur_rec;
    pst_pkg::rec_t                wr_rec;
    logic                         wr_en;
    logic                         accepted_next;
    logic [pst_pkg::OUTC_W-1:0]   outcome_next;
    logic [TW-1:0]                gap;
    logic                         in_window;
    logic                         in_burst;
    logic [pst_pkg::CNT_W-1:0]    cnt_inc;
    logic [TW:0]                  pen_sum;
    logic [TW:0]                  blk_sum;

    // handshake and stage advance
    assign s2_adv    = s2_valid_reg && (!out_valid_reg || out_ready);
    assign s2_ready  = !s2_valid_reg || s2_adv;
    assign s1_adv    = s1_valid_reg && s2_ready;
    assign in_ready  = !s1_valid_reg || s2_ready;
    assign out_valid = out_valid_reg;
    assign accepted  = accepted_reg;
    assign outcome   = outcome_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.penalty_ms   <= pst_pkg::PENALTY_RST;
            cfg_reg.window_ms    <= pst_pkg::WINDOW_RST;
            cfg_reg.max_attempts <= pst_pkg::MAXATT_RST;
            cfg_reg.burst_ms     <= pst_pkg::BURST_RST;
            cfg_reg.block_ms     <= pst_pkg::BLOCK_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pst_pkg::REG_PENALTY: cfg_reg.penalty_ms   <= cfg_data;
                pst_pkg::REG_WINDOW:  cfg_reg.window_ms    <= cfg_data;
                pst_pkg::REG_MAXATT:  cfg_reg.max_attempts <= cfg_data[pst_pkg::MAXA_W-1:0];
                pst_pkg::REG_BURST:   cfg_reg.burst_ms     <= cfg_data;
                pst_pkg::REG_BLOCK:   cfg_reg.block_ms     <= cfg_data;
                default:              cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // source address table
    pst_cam #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_cam (
        .clk       (clk),
        .rst_n     (rst_n),
        .lookup_en (s1_adv),
        .ip        (s1_ip_reg),
        .look      (cam_look),
        .idx       (cam_idx)
    );

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s2_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_ip_reg  <= client_ip;
            s1_now_reg <= now_ms;
        end
        if (s1_adv)
        begin
            s2_now_reg  <= s1_now_reg;
            s2_idx_reg  <= cam_idx;
            s2_look_reg <= cam_look;
        end
        if (s2_adv)
        begin
            accepted_reg <= accepted_next;
            outcome_reg  <= outcome_next;
        end
        if (wr_en)
        begin
            fwd_idx_reg <= s2_idx_reg;
            fwd_rec_reg <= wr_rec;
        end
    end

    // record memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rec_mem[s2_idx_reg] <= wr_rec;
        end
        if (s1_adv)
        begin
            rd_rec_reg <= rec_mem[cam_idx];
        end
    end

    // latest record for this entry: bypass the write that raced the read
    assign cur_rec = (fwd_valid_reg && (fwd_idx_reg == s2_idx_reg)) ? fwd_rec_reg
                                                                    : rd_rec_reg;

    // time arithmetic
    assign gap       = s2_now_reg - cur_rec.last_attempt;
    assign in_window = gap[TW-1] || (gap <= {{(TW-pst_pkg::MS_W){1'b0}}, cfg_reg.window_ms});
    assign in_burst  = gap[TW-1] || (gap <= {{(TW-pst_pkg::MS_W){1'b0}}, cfg_reg.burst_ms});
    assign cnt_inc   = (cur_rec.attempt_count < pst_pkg::COUNT_MAX)
                       ? cur_rec.attempt_count + pst_pkg::CNT_W'(1)
                       : cur_rec.attempt_count;
    assign pen_sum   = {1'b0, cur_rec.block_until}
                       + {{(TW+1-pst_pkg::MS_W){1'b0}}, cfg_reg.penalty_ms};
    assign blk_sum   = {1'b0, s2_now_reg}
                       + {{(TW+1-pst_pkg::MS_W){1'b0}}, cfg_reg.block_ms};

    // accept/refuse decision and record update
    always_comb
    begin
        wr_rec        = cur_rec;
        wr_en         = 1'b0;
        accepted_next = 1'b1;
        outcome_next  = pst_pkg::OUTC_FULL;
        if (!s2_look_reg.hit)
        begin
            if (!s2_look_reg.full)
            begin
                // new source
                wr_en                = s2_adv;
                wr_rec.last_attempt  = s2_now_reg;
                wr_rec.block_until   = '0;
                wr_rec.attempt_count = pst_pkg::CNT_W'(1);
                outcome_next         = pst_pkg::OUTC_NEW;
            end
        end
        else if (cur_rec.block_until > s2_now_reg)
        begin
            // still blocked: extend by the penalty
            wr_en              = s2_adv;
            wr_rec.block_until = pen_sum[TW] ? {TW{1'b1}} : pen_sum[TW-1:0];
            accepted_next      = 1'b0;
            outcome_next       = pst_pkg::OUTC_BLOCKED;
        end
        else
        begin
            wr_en               = s2_adv;
            wr_rec.last_attempt = s2_now_reg;
            if (in_window)
            begin
                wr_rec.attempt_count = cnt_inc;
                outcome_next         = pst_pkg::OUTC_COUNTED;
                if (cnt_inc > {1'b0, cfg_reg.max_attempts})
                begin
                    wr_rec.attempt_count = '0;
                    if (in_burst)
                    begin
                        wr_rec.block_until = blk_sum[TW] ? {TW{1'b1}} : blk_sum[TW-1:0];
                        accepted_next      = 1'b0;
                        outcome_next       = pst_pkg::OUTC_BLK_START;
                    end
                end
            end
            else
            begin
                wr_rec.attempt_count = pst_pkg::CNT_W'(1);
                outcome_next         = pst_pkg::OUTC_RESTART;
            end
        end
    end

endmodule

// File: verif/per_source_connection_throttle_checker.sv
// ----------------------------------------------------------------------------
// per_source_connection_throttle_checker
// Watches the request, decision and register ports of the connection
// throttle, keeps its own copy of the source table and the registers, predicts
// the decision for every accepted request and compares each accepted decision
// with the oldest prediction. Reports the failure count and the number of
// decisions still outstanding.
// ----------------------------------------------------------------------------
module per_source_connection_throttle_checker #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [pst_pkg::IP_W-1:0]     client_ip,
    input  logic [pst_pkg::TIME_W-1:0]   now_ms,
    input  logic                         cfg_we,
    input  logic [pst_pkg::RIDX_W-1:0]   cfg_index,
    input  logic [pst_pkg::MS_W-1:0]     cfg_data,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic                         accepted,
    input  logic [pst_pkg::OUTC_W-1:0]   outcome,
    output int                           fail_count,
    output int                           outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                       accepted;
        logic [pst_pkg::OUTC_W-1:0] outcome;
    } decision_t;

    // shadow of the source table and the registers
    bit                         src_live  [TABLE_ENTRIES];
    logic [pst_pkg::IP_W-1:0]   src_addr  [TABLE_ENTRIES];
    logic [pst_pkg::TIME_W-1:0] src_last  [TABLE_ENTRIES];
    logic [pst_pkg::TIME_W-1:0] src_until [TABLE_ENTRIES];
    logic [pst_pkg::CNT_W-1:0]  src_count [TABLE_ENTRIES];
    pst_pkg::cfg_t              regs;

    decision_t decision_q[$];
    int        errs = 0;

    // signed 48-bit gap at or below a non-negative limit
    function automatic logic gap_ok(logic [pst_pkg::TIME_W-1:0] gap,
                                    logic [pst_pkg::MS_W-1:0] lim);
        return gap[pst_pkg::TIME_W-1] || (gap <= pst_pkg::TIME_W'(lim));
    endfunction

    function automatic logic [pst_pkg::TIME_W-1:0] add_sat(logic [pst_pkg::TIME_W-1:0] t,
                                                           logic [pst_pkg::MS_W-1:0] d);
        logic [pst_pkg::TIME_W:0] s;
        s = {1'b0, t} + (pst_pkg::TIME_W + 1)'(d);
        return s[pst_pkg::TIME_W] ? {pst_pkg::TIME_W{1'b1}} : s[pst_pkg::TIME_W-1:0];
    endfunction

    // decide one attempt and update the shadow table
    function automatic decision_t judge_attempt(logic [pst_pkg::IP_W-1:0] ip,
                                                logic [pst_pkg::TIME_W-1:0] t);
        int                         hit;
        int                         spare;
        logic [pst_pkg::TIME_W-1:0] gap;
        decision_t                  d;
        hit   = -1;
        spare = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (src_live[i]) begin
                if (hit < 0 && src_addr[i] == ip)
                    hit = i;
            end
            else if (spare < 0) begin
                spare = i;
            end
        end

        // unknown source: record it, or let it through untracked
        if (hit < 0) begin
            d.accepted = 1'b1;
            if (spare < 0) begin
                d.outcome = pst_pkg::OUTC_FULL;
                return d;
            end
            src_live[spare]  = 1'b1;
            src_addr[spare]  = ip;
            src_last[spare]  = t;
            src_until[spare] = '0;
            src_count[spare] = pst_pkg::CNT_W'(1);
            d.outcome = pst_pkg::OUTC_NEW;
            return d;
        end

        // still blocked: refuse and push the block out
        if (src_until[hit] > t) begin
            src_until[hit] = add_sat(src_until[hit], regs.penalty_ms);
            d.accepted = 1'b0;
            d.outcome  = pst_pkg::OUTC_BLOCKED;
            return d;
        end

        gap = t - src_last[hit];
        src_last[hit] = t;
        if (gap_ok(gap, regs.window_ms)) begin
            if (src_count[hit] < pst_pkg::COUNT_MAX)
                src_count[hit] = src_count[hit] + 1'b1;
            if (src_count[hit] > pst_pkg::CNT_W'(regs.max_attempts)) begin
                src_count[hit] = '0;
                if (gap_ok(gap, regs.burst_ms)) begin
                    src_until[hit] = add_sat(t, regs.block_ms);
                    d.accepted = 1'b0;
                    d.outcome  = pst_pkg::OUTC_BLK_START;
                    return d;
                end
            end
            d.accepted = 1'b1;
            d.outcome  = pst_pkg::OUTC_COUNTED;
            return d;
        end

        // gap past the window: start counting again
        src_count[hit] = pst_pkg::CNT_W'(1);
        d.accepted = 1'b1;
        d.outcome  = pst_pkg::OUTC_RESTART;
        return d;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        decision_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                src_live[i] = 1'b0;
            regs.penalty_ms   = pst_pkg::PENALTY_RST;
            regs.window_ms    = pst_pkg::WINDOW_RST;
            regs.max_attempts = pst_pkg::MAXATT_RST;
            regs.burst_ms     = pst_pkg::BURST_RST;
            regs.block_ms     = pst_pkg::BLOCK_RST;
            decision_q.delete();
            outstanding <= 0;
            fail_count  <= errs;
        end
        else
        begin
            // compare an accepted decision with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (decision_q.size() == 0)
                begin
                    $error("decision with no request pending: accepted %0d outcome %0d",
                           accepted, outcome);
                    errs++;
                end
                else
                begin
                    want = decision_q.pop_front();
                    if (accepted !== want.accepted)
                    begin
                        $error("accepted: expected %0d, actual %0d", want.accepted, accepted);
                        errs++;
                    end
                    if (outcome !== want.outcome)
                    begin
                        $error("outcome: expected %0d, actual %0d", want.outcome, outcome);
                        errs++;
                    end
                end
            end

            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    pst_pkg::REG_PENALTY: regs.penalty_ms   = cfg_data;
                    pst_pkg::REG_WINDOW:  regs.window_ms    = cfg_data;
                    pst_pkg::REG_MAXATT:  regs.max_attempts = cfg_data[pst_pkg::MAXA_W-1:0];
                    pst_pkg::REG_BURST:   regs.burst_ms     = cfg_data;
                    pst_pkg::REG_BLOCK:   regs.block_ms     = cfg_data;
                    default: ;
                endcase
            end

            // predict each accepted request
            if (in_valid && in_ready)
                decision_q = {decision_q, judge_attempt(client_ip, now_ms)};

            outstanding <= decision_q.size();
            fail_count  <= errs;
        end
    end

endmodule

// File: verif/tb_per_source_connection_throttle_core.sv
// ----------------------------------------------------------------------------
// tb_per_source_connection_throttle_core
// Drives connection attempts into the throttle under bursty request traffic
// and a stalling receiver: a directed part at the register defaults, then
// random phases at default, low, high and random register settings. Decisions are
// checked by the checker instance; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_per_source_connection_throttle_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int                         TABLE_ENTRIES = 64;
    localparam int                         POOL_SIZE     = 48;
    localparam int                         PHASE_ITEMS   = 250;
    localparam logic [pst_pkg::TIME_W-1:0] T_TOP         = {pst_pkg::TIME_W{1'b1}};

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;
    typedef enum int {STEP_NONE, STEP_BURST, STEP_WINDOW, STEP_PAST, STEP_FAR} step_t;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_ready;
    logic [pst_pkg::IP_W-1:0]     client_ip = '0;
    logic [pst_pkg::TIME_W-1:0]   now_ms    = '0;
    logic                         cfg_we    = 1'b0;
    logic [pst_pkg::RIDX_W-1:0]   cfg_index = '0;
    logic [pst_pkg::MS_W-1:0]     cfg_data  = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic                         accepted;
    logic [pst_pkg::OUTC_W-1:0]   outcome;

    int fail_count;
    int outstanding;

    per_source_connection_throttle_core #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .client_ip (client_ip),
        .now_ms    (now_ms),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .accepted  (accepted),
        .outcome   (outcome)
    );

    per_source_connection_throttle_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .client_ip   (client_ip),
        .now_ms      (now_ms),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .accepted    (accepted),
        .outcome     (outcome),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // receiver stall pattern, switched to a new random mode when its countdown runs out
    rx_mode_t rx_mode   = RX_OPEN;
    int       mode_left = 0;
    int       beat      = 0;

    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            rx_mode   <= rx_mode_t'($urandom_range(3));
            mode_left <= $urandom_range(150, 30);
        end
        else
        begin
            mode_left <= mode_left - 1;
        end
        beat <= beat + 1;
        case (rx_mode)
            RX_OPEN:  out_ready <= 1'b1;
            RX_LIGHT: out_ready <= ($urandom_range(3) != 0);
            RX_HEAVY: out_ready <= ($urandom_range(3) == 0);
            default:  out_ready <= (beat % 4 == 0);
        endcase
    end

    // stimulus state
    pst_pkg::cfg_t              plan;
    logic [pst_pkg::IP_W-1:0]   pool [POOL_SIZE];
    logic [pst_pkg::TIME_W-1:0] t_now;
    int                         burst_left = 0;
    int                         items_sent = 0;

    function automatic logic [pst_pkg::TIME_W-1:0] pick_step(step_t kind);
        case (kind)
            STEP_NONE:   return '0;
            STEP_BURST:  return pst_pkg::TIME_W'($urandom_range(plan.burst_ms, 0));
            STEP_WINDOW: return pst_pkg::TIME_W'($urandom_range(plan.window_ms, 0));
            STEP_PAST:   return pst_pkg::TIME_W'(plan.window_ms)
                                + pst_pkg::TIME_W'($urandom_range(2000, 1));
            default:     return {16'($urandom), 32'($urandom)};
        endcase
    endfunction

    // one request, with bursts and gaps on the request side
    task automatic send_attempt(input logic [pst_pkg::IP_W-1:0] ip,
                                input logic [pst_pkg::TIME_W-1:0] t);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
            burst_left = $urandom_range(16, 1);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid  <= 1'b1;
        client_ip <= ip;
        now_ms    <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    // drain all decisions, then let the pipeline settle
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic put_reg(input logic [pst_pkg::RIDX_W-1:0] idx,
                           input logic [pst_pkg::MS_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    task automatic apply_settings(input pst_pkg::cfg_t c);
        wait_idle();
        put_reg(pst_pkg::REG_PENALTY, c.penalty_ms);
        put_reg(pst_pkg::REG_WINDOW, c.window_ms);
        put_reg(pst_pkg::REG_MAXATT, pst_pkg::MS_W'(c.max_attempts));
        put_reg(pst_pkg::REG_BURST, c.burst_ms);
        put_reg(pst_pkg::REG_BLOCK, c.block_ms);
        @(negedge clk);
        cfg_we <= 1'b0;
        plan = c;
    endtask

    // random traffic: mostly bursts on one source, plus noise
    task automatic run_phase(input int n_items);
        int                       start;
        int                       r;
        int                       n;
        logic [pst_pkg::IP_W-1:0] ip;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            r  = $urandom_range(99);
            ip = pool[$urandom_range(POOL_SIZE - 1)];
            if (r < 45)
            begin
                // hammering one source with short gaps
                n = $urandom_range(20, 2);
                repeat (n)
                begin
                    r = $urandom_range(9);
                    t_now += pick_step(r < 2 ? STEP_NONE : (r < 9 ? STEP_BURST : STEP_WINDOW));
                    send_attempt(ip, t_now);
                end
            end
            else if (r < 60)
            begin
                // scattered sources and gaps
                n = $urandom_range(10, 1);
                repeat (n)
                begin
                    t_now += pick_step(step_t'($urandom_range(4)));
                    send_attempt(pool[$urandom_range(POOL_SIZE - 1)], t_now);
                end
            end
            else if (r < 70)
            begin
                // slow source, gaps past the window
                n = $urandom_range(4, 1);
                repeat (n)
                begin
                    t_now += pick_step(STEP_PAST);
                    send_attempt(ip, t_now);
                end
            end
            else if (r < 78)
            begin
                // unseen sources fill the table
                n = $urandom_range(3, 1);
                repeat (n)
                begin
                    t_now += pick_step(STEP_BURST);
                    send_attempt($urandom, t_now);
                end
            end
            else if (r < 88)
            begin
                // time jump, sometimes to the top of the range
                if ($urandom_range(1) == 0)
                    t_now = {16'($urandom), 32'($urandom)};
                else
                    t_now = T_TOP - pst_pkg::TIME_W'($urandom_range(6000));
                send_attempt(ip, t_now);
            end
            else
            begin
                // time going backwards
                t_now -= pst_pkg::TIME_W'($urandom_range(int'(plan.window_ms) + 100, 1));
                send_attempt(ip, t_now);
            end
        end
    endtask

    initial
    begin
        pst_pkg::cfg_t c;
        plan.penalty_ms   = pst_pkg::PENALTY_RST;
        plan.window_ms    = pst_pkg::WINDOW_RST;
        plan.max_attempts = pst_pkg::MAXATT_RST;
        plan.burst_ms     = pst_pkg::BURST_RST;
        plan.block_ms     = pst_pkg::BLOCK_RST;
        pool[0] = '0;
        pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            pool[i] = $urandom;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part at the register defaults
        send_attempt(32'h0000_0000, 48'd0);          // new source at time zero
        send_attempt(32'hFFFF_FFFF, T_TOP);          // new source at the top of time
        send_attempt(32'h0000_0000, 48'd100);        // counted
        send_attempt(32'h0000_0000, 48'd200);
        send_attempt(32'h0000_0000, 48'd300);
        send_attempt(32'h0000_0000, 48'd400);
        send_attempt(32'h0000_0000, 48'd500);        // over the limit in a burst: block
        send_attempt(32'h0000_0000, 48'd600);        // still blocked, extended
        send_attempt(32'h0000_0000, 48'd3750);       // block ends exactly here
        send_attempt(32'h0000_0000, 48'd20000);      // past the window: restart
        send_attempt(32'h0000_0000, 48'd10);         // time went backwards
        send_attempt(32'h0000_0000, 48'd1000);       // over the limit at 4000: no block
        send_attempt(32'h0000_0000, 48'd2000);
        send_attempt(32'h0000_0000, 48'd3000);
        send_attempt(32'h0000_0000, 48'd4000);
        send_attempt(32'hFFFF_FFFF, T_TOP);          // burst at the top of time
        send_attempt(32'hFFFF_FFFF, T_TOP);
        send_attempt(32'hFFFF_FFFF, T_TOP);
        send_attempt(32'hFFFF_FFFF, T_TOP);
        send_attempt(32'hFFFF_FFFF, T_TOP);          // block end saturates
        send_attempt(32'hFFFF_FFFF, T_TOP - 1'b1);   // penalty saturates
        send_attempt(32'hAAAA_5555, 48'h5555_AAAA_5555);
        send_attempt(32'h5555_AAAA, 48'hAAAA_5555_AAAA);

        // random phases over several settings
        t_now = {16'($urandom), 32'($urandom)};
        run_phase(PHASE_ITEMS);

        c = '{penalty_ms: '0, window_ms: '0, max_attempts: 4'd1, burst_ms: '0, block_ms: '0};
        apply_settings(c);
        run_phase(PHASE_ITEMS);

        c = '{penalty_ms: '1, window_ms: '1, max_attempts: 4'd15, burst_ms: '1, block_ms: '1};
        apply_settings(c);
        run_phase(PHASE_ITEMS);

        repeat (3)
        begin
            c.penalty_ms   = pst_pkg::MS_W'($urandom_range(1000));
            c.window_ms    = pst_pkg::MS_W'($urandom_range(8000));
            c.max_attempts = pst_pkg::MAXA_W'($urandom_range(15, 1));
            c.burst_ms     = ($urandom_range(3) == 0) ? pst_pkg::MS_W'($urandom)
                                                      : pst_pkg::MS_W'($urandom_range(c.window_ms));
            c.block_ms     = pst_pkg::MS_W'($urandom_range(6000));
            apply_settings(c);
            run_phase(PHASE_ITEMS);
        end

        c = '{penalty_ms:   pst_pkg::PENALTY_RST,
              window_ms:    pst_pkg::WINDOW_RST,
              max_attempts: pst_pkg::MAXATT_RST,
              burst_ms:     pst_pkg::BURST_RST,
              block_ms:     pst_pkg::BLOCK_RST};
        apply_settings(c);
        run_phase(PHASE_ITEMS);

        // drain and give the verdict
        wait_idle();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
sv/pst_pkg.sv
sv/pst_cam.sv
sv/per_source_connection_throttle_core.sv
verif/per_source_connection_throttle_checker.sv
verif/tb_per_source_connection_throttle_core.sv
